// ===== src/base64_stream_encoder_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Checked only while out of reset.
`define B64_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define B64_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/b64enc_pkg.sv =====
package b64enc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [6:0] CHAR_PAD   = 7'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // Character slot that closes a group.
    localparam logic [1:0] SLOT_LAST = 2'd3;
    localparam logic [1:0] HELD_MAX  = 2'd2;
    localparam logic [1:0] GROUP_FULL = 2'd3;

    // One group handed from the front to the back.
    typedef struct packed {
        logic [23:0] group;    // zero-filled, first byte in bits 23..16
        logic [1:0]  nbytes;   // bytes in the group, 1..3
        logic        eom;
    } grp_entry_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v_in);
        logic [5:0] v;
        logic [6:0] vx;
        v  = v_in & SEXTET_MASK;
        vx = {1'b0, v};
        if (v < 6'd26)
            return vx + 7'h41;
        else if (v < 6'd52)
            return vx + 7'h47;            // 'a' - 26
        else if (v < 6'd62)
            return vx - 7'd4;             // '0' - 52
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

// ===== src/b64enc_front.sv =====
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       q_full,
    output logic       q_push,
    output grp_entry_t q_entry
);

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [1:0]  cnt;
    logic [1:0]  n;
    logic        accept;
    logic        complete;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt      = (held_count_reg > HELD_MAX) ? HELD_MAX : held_count_reg;
    assign n        = cnt + 2'd1;
    assign complete = (n == GROUP_FULL) || end_of_message;
    assign q_push   = accept && complete;

    always_comb
    begin
        q_entry.nbytes = n;
        q_entry.eom    = end_of_message;
        unique case (cnt)
            2'd0:    q_entry.group = {data_byte, 16'h0000};
            2'd1:    q_entry.group = {held_bytes_reg[15:8], data_byte, 8'h00};
            default: q_entry.group = {held_bytes_reg, data_byte};
        endcase
    end

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (complete)
            begin
                held_bytes_next = 16'h0000;
                held_count_next = 2'd0;
            end
            else
            begin
                if (cnt == 2'd0)
                    held_bytes_next = {data_byte, 8'h00};
                else
                    held_bytes_next = {held_bytes_reg[15:8], data_byte};
                held_count_next = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'h0000;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// ===== src/b64enc_queue.sv =====
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grp_entry_t wr_entry,
    output logic       full,
    input  logic       pop,
    output logic       rd_valid,
    output grp_entry_t rd_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    grp_entry_t      slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;
    assign rd_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/b64enc_back.sv =====
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  grp_entry_t q_entry,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       last_char
);

    logic [1:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       emit;
    logic [5:0] sextet;

    assign load = !valid_reg || out_ready;
    assign emit = load && q_valid;
    assign q_pop = emit && (slot_reg == SLOT_LAST);

    always_comb
    begin
        unique case (slot_reg)
            2'd0:    sextet = q_entry.group[23:18];
            2'd1:    sextet = q_entry.group[17:12];
            2'd2:    sextet = q_entry.group[11:6];
            default: sextet = q_entry.group[5:0];
        endcase
    end

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
            valid_next = q_valid;
        if (emit)
        begin
            // slot i carries data while i <= bytes in group
            char_next = (slot_reg <= q_entry.nbytes) ? sextet_char(sextet) : CHAR_PAD;
            last_next = q_entry.eom && (slot_reg == SLOT_LAST);
            slot_next = slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

endmodule

// ===== src/base64_stream_encoder_top.sv =====
// Byte-stream base64 encoder (standard alphabet, '=' padding).
// Input channel s_axis: one raw byte per word in tdata, tlast on the final
// byte of a message. Output channel m_axis: one ASCII character per word in
// tdata[6:0], tlast on the final character of the encoded message.
// Every three bytes, or a shorter group closed by tlast, produce four
// characters; a short group is zero-filled and padded with "=" or "==".
// The byte that closes a group is written into the group queue; its first
// character is then registered in the output stage and shown on m_axis.
// Throughput: the output stage emits one character per cycle while
// m_axis_tready is high, so the sustained input rate is three bytes per
// four characters out. The front takes bytes every cycle while the group
// queue has room, so bursts of up to QUEUE_DEPTH groups are absorbed.
// Stall: when m_axis_tready is low the output word holds, the queue fills
// and s_axis_tready drops; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the queue, drops any partial group
// and clears m_axis_tvalid.
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // last_char
);

    grp_entry_t push_entry;
    grp_entry_t head_entry;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    logic [6:0] out_char;

    b64enc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata),
        .end_of_message (s_axis_tlast),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (push_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (head_entry)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (head_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .last_char (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== src/b64enc_checker.sv =====
`include "base64_stream_encoder_top_macros.svh"

module b64enc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic [7:0] d;
    logic       in_alphabet;
    logic       out_stall;
    logic       pad_taken;

    assign d = m_axis_tdata;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign pad_taken = m_axis_tvalid && m_axis_tready && (d == 8'h3D) && !m_axis_tlast;
    assign in_alphabet = (d >= 8'h41 && d <= 8'h5A) || (d >= 8'h61 && d <= 8'h7A)
                      || (d >= 8'h30 && d <= 8'h39) || (d == 8'h2B) || (d == 8'h2F)
                      || (d == 8'h3D);

    // output word must hold while stalled
    property p_out_hold;
        out_stall |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast);
    endproperty

    // padding is only ever followed by more padding within a group
    property p_pad_tail;
        pad_taken ##1 m_axis_tvalid |-> d == 8'h3D;
    endproperty

    `B64_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "output word changed while stalled")

    `B64_ASSERT(a_alphabet, clk, rst_n, m_axis_tvalid |-> in_alphabet, "char outside alphabet")

    `B64_ASSERT(a_pad_tail, clk, rst_n, p_pad_tail, "data character after padding")

    `B64_ASSERT_ALWAYS(a_reset_idle, clk, rst_n && $past(!rst_n) |-> !m_axis_tvalid, "valid out of reset")

endmodule

bind base64_stream_encoder_top b64enc_checker u_b64enc_checker (.*);
